### hdl/assert_macros.svh
// Assertion macros shared by the frame checker RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define LFC_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame checker assertion failed");

// Next-cycle implication, disabled in reset
`define LFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame checker assertion failed");

`endif

### hdl/lfc_pkg.sv
// Types, codes and constants of the link frame checker.
// No dependencies; imported by every RTL module of the block.
package lfc_pkg;

    localparam logic [5:0] HDR_DONE       = 6'd42;
    localparam logic [5:0] HEAD_SUM_HI    = 6'd24;
    localparam logic [5:0] HEAD_SUM_LO    = 6'd25;
    localparam logic [5:0] DATA_SUM_HI    = 6'd40;
    localparam logic [5:0] DATA_SUM_LO    = 6'd41;
    localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_RECORD  = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK,
        STATUS_SHORT,
        STATUS_HEAD_SUM,
        STATUS_LENGTH,
        STATUS_DATA_SUM
    } status_t;

    typedef enum logic [2:0] {
        SLOT_DMAC,
        SLOT_SMAC,
        SLOT_PROTO,
        SLOT_IP,
        SLOT_PORTS,
        SLOT_NONE
    } slot_t;

    // One result item as it leaves the block
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] protocol_word;
        logic [15:0] service_type;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] data_length;
    } result_t;

    // Results one byte produces
    typedef struct packed {
        logic pay;
        logic rec;
    } push_t;

    // Capture register for each header byte offset
    function automatic slot_t slot_of(input logic [5:0] idx);
        slot_t s;
        case (idx) inside
            [6'd0:6'd5]:   s = SLOT_DMAC;
            [6'd6:6'd11]:  s = SLOT_SMAC;
            [6'd12:6'd13]: s = SLOT_PROTO;
            [6'd16:6'd17]: s = SLOT_PROTO;
            [6'd26:6'd33]: s = SLOT_IP;
            [6'd34:6'd39]: s = SLOT_PORTS;
            default:       s = SLOT_NONE;
        endcase
        return s;
    endfunction

endpackage

### hdl/lfc_frame_state.sv
// Frame state of the checker: header capture, checksum lanes, payload count.
// Depends on lfc_pkg and assert_macros.svh.
module lfc_frame_state (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       frame_byte,
    input  logic             frame_last,
    output lfc_pkg::push_t   push,
    output lfc_pkg::result_t pay_result,
    output lfc_pkg::result_t rec_result
);
    import lfc_pkg::*;

    `include "assert_macros.svh"

    logic [5:0]  header_index_reg, header_index_next;
    logic [16:0] payload_count_reg, payload_count_next;
    logic [7:0]  head_even_reg, head_even_next;
    logic [7:0]  head_odd_reg, head_odd_next;
    logic [7:0]  data_even_reg, data_even_next;
    logic [7:0]  data_odd_reg, data_odd_next;
    logic [15:0] stored_head_reg, stored_head_next;
    logic [15:0] stored_data_reg, stored_data_next;
    logic        header_good_reg, header_good_next;
    logic [47:0] dmac_reg, dmac_next;
    logic [47:0] smac_reg, smac_next;
    logic [31:0] proto_reg, proto_next;
    logic [63:0] ip_reg, ip_next;
    logic [47:0] ports_reg, ports_next;

    logic        in_header;
    logic [7:0]  summed;
    status_t     st;

    assign in_header = (header_index_reg < HDR_DONE);

    // Compute next frame state for the byte at the input
    always_comb
    begin
        header_index_next  = header_index_reg;
        payload_count_next = payload_count_reg;
        head_even_next     = head_even_reg;
        head_odd_next      = head_odd_reg;
        data_even_next     = data_even_reg;
        data_odd_next      = data_odd_reg;
        stored_head_next   = stored_head_reg;
        stored_data_next   = stored_data_reg;
        header_good_next   = header_good_reg;
        dmac_next          = dmac_reg;
        smac_next          = smac_reg;
        proto_next         = proto_reg;
        ip_next            = ip_reg;
        ports_next         = ports_reg;
        summed             = frame_byte;

        if (in_header)
        begin
            // Stored header checksum counts as zero in the header sum
            if (header_index_reg == HEAD_SUM_HI || header_index_reg == HEAD_SUM_LO)
            begin
                stored_head_next = {stored_head_reg[7:0], frame_byte};
                summed           = 8'd0;
            end
            if (header_index_reg == DATA_SUM_HI || header_index_reg == DATA_SUM_LO)
            begin
                stored_data_next = {stored_data_reg[7:0], frame_byte};
            end
            if (!header_index_reg[0])
            begin
                head_even_next = head_even_reg + summed;
            end
            else
            begin
                head_odd_next = head_odd_reg + summed;
            end

            case (slot_of(header_index_reg))
                SLOT_DMAC:  dmac_next  = {dmac_reg[39:0], frame_byte};
                SLOT_SMAC:  smac_next  = {smac_reg[39:0], frame_byte};
                SLOT_PROTO: proto_next = {proto_reg[23:0], frame_byte};
                SLOT_IP:    ip_next    = {ip_reg[55:0], frame_byte};
                SLOT_PORTS: ports_next = {ports_reg[39:0], frame_byte};
                default:    ;
            endcase

            header_index_next = header_index_reg + 6'd1;
            if (header_index_next == HDR_DONE)
            begin
                header_good_next = ({head_even_next, head_odd_next} == stored_head_next);
            end
        end
        else
        begin
            if (!payload_count_reg[0])
            begin
                data_even_next = data_even_reg + frame_byte;
            end
            else
            begin
                data_odd_next = data_odd_reg + frame_byte;
            end
            if (payload_count_reg != COUNT_MAX)
            begin
                payload_count_next = payload_count_reg + 17'd1;
            end
        end
    end

    // Pick the results this byte produces
    assign push.pay = !in_header && header_good_reg;
    assign push.rec = frame_last;

    always_comb
    begin
        pay_result              = '0;
        pay_result.kind         = KIND_PAYLOAD;
        pay_result.payload_byte = frame_byte;
    end

    // Build the end-of-frame record from the updated state
    always_comb
    begin
        rec_result      = '0;
        rec_result.kind = KIND_RECORD;
        st              = STATUS_SHORT;
        if (header_index_next == HDR_DONE)
        begin
            if (!header_good_next)
            begin
                st = STATUS_HEAD_SUM;
            end
            else if (payload_count_next != {1'b0, ports_next[15:0]})
            begin
                st = STATUS_LENGTH;
            end
            else if ({data_even_next, data_odd_next} != stored_data_next)
            begin
                st = STATUS_DATA_SUM;
            end
            else
            begin
                st = STATUS_OK;
            end
            rec_result.dest_mac      = dmac_next;
            rec_result.source_mac    = smac_next;
            rec_result.protocol_word = proto_next[31:16];
            rec_result.service_type  = proto_next[15:0];
            rec_result.source_ip     = ip_next[63:32];
            rec_result.dest_ip       = ip_next[31:0];
            rec_result.source_port   = ports_next[47:32];
            rec_result.dest_port     = ports_next[31:16];
            rec_result.data_length   = ports_next[15:0];
        end
        rec_result.status = st;
    end

    // Advance frame state; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg  <= '0;
            payload_count_reg <= '0;
            head_even_reg     <= '0;
            head_odd_reg      <= '0;
            data_even_reg     <= '0;
            data_odd_reg      <= '0;
            stored_head_reg   <= '0;
            stored_data_reg   <= '0;
            header_good_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (frame_last)
            begin
                header_index_reg  <= '0;
                payload_count_reg <= '0;
                head_even_reg     <= '0;
                head_odd_reg      <= '0;
                data_even_reg     <= '0;
                data_odd_reg      <= '0;
                stored_head_reg   <= '0;
                stored_data_reg   <= '0;
                header_good_reg   <= 1'b0;
            end
            else
            begin
                header_index_reg  <= header_index_next;
                payload_count_reg <= payload_count_next;
                head_even_reg     <= head_even_next;
                head_odd_reg      <= head_odd_next;
                data_even_reg     <= data_even_next;
                data_odd_reg      <= data_odd_next;
                stored_head_reg   <= stored_head_next;
                stored_data_reg   <= stored_data_next;
                header_good_reg   <= header_good_next;
            end
        end
    end

    // Hold captured fields; every field is fully rewritten by its own header bytes
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dmac_reg  <= dmac_next;
            smac_reg  <= smac_next;
            proto_reg <= proto_next;
            ip_reg    <= ip_next;
            ports_reg <= ports_next;
        end
    end

    `LFC_ASSERT(a_good_needs_header, header_good_reg, header_index_reg == HDR_DONE)
    `LFC_ASSERT(a_count_needs_header, payload_count_reg != '0, header_index_reg == HDR_DONE)
    `LFC_ASSERT_NEXT(a_clear_after_last, take && frame_last,
                     header_index_reg == '0 && payload_count_reg == '0 && !header_good_reg)

endmodule

### hdl/lfc_result_queue.sv
// Two-entry result queue that takes up to two results per cycle.
// Depends on lfc_pkg and assert_macros.svh.
module lfc_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  lfc_pkg::push_t   push,
    input  lfc_pkg::result_t pay_data,
    input  lfc_pkg::result_t rec_data,
    input  logic             pop,
    output lfc_pkg::result_t head,
    output logic             head_valid,
    output logic [1:0]       free
);
    import lfc_pkg::*;

    `include "assert_macros.svh"

    result_t    entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic [1:0] npush;
    logic       rec_slot;

    assign npush      = {1'b0, push.pay} + {1'b0, push.rec};
    assign rec_slot   = push.pay ? ~wr_ptr_reg : wr_ptr_reg;
    assign count_next = count_reg + npush - {1'b0, pop};
    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);
    assign free       = 2'd2 - count_reg;

    // Write payload result first, then the record behind it
    always_ff @(posedge clk)
    begin
        if (push.pay)
        begin
            entry_reg[wr_ptr_reg] <= pay_data;
        end
        if (push.rec)
        begin
            entry_reg[rec_slot] <= rec_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ npush[0];
            rd_ptr_reg <= rd_ptr_reg ^ pop;
            count_reg  <= count_next;
        end
    end

    `LFC_ASSERT(a_no_overflow, 1'b1, count_reg <= 2'd2)
    `LFC_ASSERT(a_push_fits, push.pay || push.rec, npush <= free + {1'b0, pop})
    `LFC_ASSERT_NEXT(a_drain, pop && count_reg == 2'd1 && !push.pay && !push.rec,
                     !head_valid)

endmodule

### hdl/link_frame_checker_top.sv
// Top level of the link frame checker: input register, frame state, result queue.
// Depends on lfc_pkg, lfc_frame_state, lfc_result_queue and assert_macros.svh.
//
//  channel | handshake            | fields
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | rx_byte, is_last
//  out     | out_valid / out_ready| result_kind, payload_byte, status, header fields
//
// One byte is taken per cycle while the queue has room; a byte that yields a payload byte
// and the status record takes two queue entries, and the queue drains one entry a cycle
// while out_ready is high. Bytes pass the input register, then the result queue entry.
// Reset clears frame counters and sums, not captured fields; no clearing pass is needed.
// The input register drains into the queue when its free entries cover the
// results of the held byte, so out_ready never reaches in_ready combinationally.
module link_frame_checker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [2:0]  status,
    output logic [47:0] dest_mac,
    output logic [47:0] source_mac,
    output logic [15:0] protocol_word,
    output logic [15:0] service_type,
    output logic [31:0] source_ip,
    output logic [31:0] dest_ip,
    output logic [15:0] source_port,
    output logic [15:0] dest_port,
    output logic [15:0] data_length
);
    import lfc_pkg::*;

    `include "assert_macros.svh"

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       fire;
    logic [1:0] need;
    logic [1:0] free;
    push_t      push;
    push_t      push_q;
    result_t    pay_result;
    result_t    rec_result;
    result_t    head;

    assign need     = {1'b0, push.pay} + {1'b0, push.rec};
    assign fire     = in_valid_reg && (free >= need);
    assign in_ready = !in_valid_reg || fire;

    assign push_q.pay = fire && push.pay;
    assign push_q.rec = fire && push.rec;

    // Hold the accepted transaction until the queue has room for its results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
            in_last_reg <= is_last;
        end
    end

    lfc_frame_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (fire),
        .frame_byte (in_byte_reg),
        .frame_last (in_last_reg),
        .push       (push),
        .pay_result (pay_result),
        .rec_result (rec_result)
    );

    lfc_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_q),
        .pay_data   (pay_result),
        .rec_data   (rec_result),
        .pop        (out_valid && out_ready),
        .head       (head),
        .head_valid (out_valid),
        .free       (free)
    );

    // Drive result ports from the queue head
    assign result_kind   = head.kind;
    assign payload_byte  = head.payload_byte;
    assign status        = head.status;
    assign dest_mac      = head.dest_mac;
    assign source_mac    = head.source_mac;
    assign protocol_word = head.protocol_word;
    assign service_type  = head.service_type;
    assign source_ip     = head.source_ip;
    assign dest_ip       = head.dest_ip;
    assign source_port   = head.source_port;
    assign dest_port     = head.dest_port;
    assign data_length   = head.data_length;

    `LFC_ASSERT_NEXT(a_stalled_byte_holds, in_valid_reg && !fire,
                     in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg))

endmodule

### test/link_frame_checker_top_test.sv
// Self-checking bench for link_frame_checker_top: random and directed frames in, each
// payload byte and status record compared against a byte-level model of the checker.
// Depends on lfc_pkg and the link_frame_checker_top RTL.
module link_frame_checker_top_test;

    import lfc_pkg::*;

    localparam int HEAD_LEN      = HDR_DONE;
    localparam int RANDOM_BYTES  = 240;
    localparam int TAIL_CYCLES   = 8;
    localparam int LIMIT_CYCLES  = 2000000;
    localparam int BUSY_GAP_PCT  = 67;
    localparam int BOTH_GAP_PCT  = 18;
    localparam int FILL_RANDOM   = -1;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_t;

    // One byte waiting to be sent, with the idling it runs under
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        idle_t      mode;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] protocol_word;
    logic [15:0] service_type;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] data_length;

    frame_byte_t byte_stream[$];
    result_t     frame_results_due[$];
    idle_t       stall_mode = IDLE_NONE;
    int          error_count = 0;
    int          result_count = 0;
    int          cycle_count = 0;
    int          queued_bytes = 0;

    // Model state of the frame in progress
    logic [7:0]  head_bytes [HEAD_LEN] = '{default: 8'd0};
    logic [5:0]  head_taken = 6'd0;
    logic [16:0] payload_seen = 17'd0;
    logic [7:0]  data_even = 8'd0;
    logic [7:0]  data_odd = 8'd0;
    logic        head_good = 1'b0;

    link_frame_checker_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .payload_byte  (payload_byte),
        .status        (status),
        .dest_mac      (dest_mac),
        .source_mac    (source_mac),
        .protocol_word (protocol_word),
        .service_type  (service_type),
        .source_ip     (source_ip),
        .dest_ip       (dest_ip),
        .source_port   (source_port),
        .dest_port     (dest_port),
        .data_length   (data_length)
    );

    always #5 clk = ~clk;

    task automatic report_error(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("result %0d: %s is %0h, want %0h",
                                   result_count, name, got, want));
    endtask

    function automatic int gap_percent(input idle_t mode, input bit recv_side);
        case (mode)
            IDLE_SEND: return recv_side ? 0 : BUSY_GAP_PCT;
            IDLE_RECV: return recv_side ? BUSY_GAP_PCT : 0;
            IDLE_BOTH: return BOTH_GAP_PCT;
            default:   return 0;
        endcase
    endfunction

    // Advance the frame model by one byte and queue the results it causes
    task automatic track_frame_byte(input logic [7:0] b, input logic last);
        result_t    r;
        logic [7:0] lane_even;
        logic [7:0] lane_odd;
        int         i;
        if (head_taken < HDR_DONE)
        begin
            head_bytes[head_taken] = b;
            head_taken++;
            // header complete: sum both lanes, stored sum bytes count as zero
            if (head_taken == HDR_DONE)
            begin
                lane_even = 8'd0;
                lane_odd = 8'd0;
                for (i = 0; i < HEAD_LEN; i++)
                begin
                    if (i == HEAD_SUM_HI || i == HEAD_SUM_LO)
                        continue;
                    if (i % 2 == 0)
                        lane_even += head_bytes[i];
                    else
                        lane_odd += head_bytes[i];
                end
                head_good = ({lane_even, lane_odd} ==
                             {head_bytes[HEAD_SUM_HI], head_bytes[HEAD_SUM_LO]});
            end
        end
        else
        begin
            if (!payload_seen[0])
                data_even += b;
            else
                data_odd += b;
            if (payload_seen != COUNT_MAX)
                payload_seen++;
            if (head_good)
            begin
                r = '0;
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                frame_results_due.push_back(r);
            end
        end

        // close the frame: status record, then clear everything
        if (last)
        begin
            r = '0;
            r.kind = KIND_RECORD;
            if (head_taken < HDR_DONE)
                r.status = STATUS_SHORT;
            else
            begin
                r.dest_mac = {head_bytes[0], head_bytes[1], head_bytes[2],
                              head_bytes[3], head_bytes[4], head_bytes[5]};
                r.source_mac = {head_bytes[6], head_bytes[7], head_bytes[8],
                                head_bytes[9], head_bytes[10], head_bytes[11]};
                r.protocol_word = {head_bytes[12], head_bytes[13]};
                r.service_type = {head_bytes[16], head_bytes[17]};
                r.source_ip = {head_bytes[26], head_bytes[27], head_bytes[28], head_bytes[29]};
                r.dest_ip = {head_bytes[30], head_bytes[31], head_bytes[32], head_bytes[33]};
                r.source_port = {head_bytes[34], head_bytes[35]};
                r.dest_port = {head_bytes[36], head_bytes[37]};
                r.data_length = {head_bytes[38], head_bytes[39]};
                if (!head_good)
                    r.status = STATUS_HEAD_SUM;
                else if (payload_seen != {1'b0, r.data_length})
                    r.status = STATUS_LENGTH;
                else if ({data_even, data_odd} !=
                         {head_bytes[DATA_SUM_HI], head_bytes[DATA_SUM_LO]})
                    r.status = STATUS_DATA_SUM;
                else
                    r.status = STATUS_OK;
            end
            frame_results_due.push_back(r);
            head_bytes = '{default: 8'd0};
            head_taken = 6'd0;
            payload_seen = 17'd0;
            data_even = 8'd0;
            data_odd = 8'd0;
            head_good = 1'b0;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last, input idle_t mode);
        frame_byte_t fb;
        fb.data = b;
        fb.last = last;
        fb.mode = mode;
        byte_stream.push_back(fb);
        queued_bytes++;
    endtask

    // Queue random bytes with the last mark on the final one
    task automatic queue_raw(input int len, input idle_t mode);
        int i;
        for (i = 0; i < len; i++)
            push_byte(8'($urandom), i == len - 1, mode);
    endtask

    // Queue a frame with consistent length and sums, then break what is asked
    task automatic queue_frame(input int body_len, input int fill, input bit bad_head,
                               input bit bad_len, input bit bad_dsum, input idle_t mode);
        logic [7:0]  hdr [HEAD_LEN];
        logic [7:0]  body [$];
        logic [7:0]  lane_even;
        logic [7:0]  lane_odd;
        logic [15:0] declared;
        int          i;
        for (i = 0; i < HEAD_LEN; i++)
            hdr[i] = (fill == FILL_RANDOM) ? 8'($urandom) : 8'(fill);
        lane_even = 8'd0;
        lane_odd = 8'd0;
        for (i = 0; i < body_len; i++)
        begin
            body.push_back((fill == FILL_RANDOM) ? 8'($urandom) : 8'(fill));
            if (i % 2 == 0)
                lane_even += body[i];
            else
                lane_odd += body[i];
        end

        // declared length and payload sum
        declared = 16'(body_len);
        if (bad_len)
            declared ^= 16'(1 << $urandom_range(15));
        hdr[38] = declared[15:8];
        hdr[39] = declared[7:0];
        hdr[DATA_SUM_HI] = lane_even;
        hdr[DATA_SUM_LO] = lane_odd;
        if (bad_dsum)
            hdr[DATA_SUM_HI + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));

        // header sum over everything but its own two bytes
        lane_even = 8'd0;
        lane_odd = 8'd0;
        for (i = 0; i < HEAD_LEN; i++)
        begin
            if (i == HEAD_SUM_HI || i == HEAD_SUM_LO)
                continue;
            if (i % 2 == 0)
                lane_even += hdr[i];
            else
                lane_odd += hdr[i];
        end
        hdr[HEAD_SUM_HI] = lane_even;
        hdr[HEAD_SUM_LO] = lane_odd;
        if (bad_head)
            hdr[$urandom_range(HEAD_LEN - 1)] ^= 8'(1 << $urandom_range(7));

        for (i = 0; i < HEAD_LEN; i++)
            push_byte(hdr[i], body_len == 0 && i == HEAD_LEN - 1, mode);
        for (i = 0; i < body_len; i++)
            push_byte(body[i], i == body_len - 1, mode);
    endtask

    // Driver: present queued bytes, model each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        frame_byte_t nxt;
        bit          launch;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'd0;
            is_last <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_frame_byte(rx_byte, is_last);
            // hold until accepted, then maybe idle before the next byte
            if (!in_valid || in_ready)
            begin
                launch = byte_stream.size() != 0 &&
                         $urandom_range(99) >= gap_percent(byte_stream[0].mode, 1'b0);
                if (launch)
                begin
                    nxt = byte_stream.pop_front();
                    in_valid <= 1'b1;
                    rx_byte <= nxt.data;
                    is_last <= nxt.last;
                    stall_mode <= nxt.mode;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest one due
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_results_due.size() == 0)
                    report_error($sformatf("result %0d arrived with none due", result_count));
                else
                begin
                    want = frame_results_due.pop_front();
                    check_field("result_kind", 64'(result_kind), 64'(want.kind));
                    check_field("payload_byte", 64'(payload_byte), 64'(want.payload_byte));
                    check_field("status", 64'(status), 64'(want.status));
                    check_field("dest_mac", 64'(dest_mac), 64'(want.dest_mac));
                    check_field("source_mac", 64'(source_mac), 64'(want.source_mac));
                    check_field("protocol_word", 64'(protocol_word), 64'(want.protocol_word));
                    check_field("service_type", 64'(service_type), 64'(want.service_type));
                    check_field("source_ip", 64'(source_ip), 64'(want.source_ip));
                    check_field("dest_ip", 64'(dest_ip), 64'(want.dest_ip));
                    check_field("source_port", 64'(source_port), 64'(want.source_port));
                    check_field("dest_port", 64'(dest_port), 64'(want.dest_port));
                    check_field("data_length", 64'(data_length), 64'(want.data_length));
                end
                result_count++;
            end
            out_ready <= $urandom_range(99) >= gap_percent(stall_mode, 1'b1);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("link_frame_checker_top_test: done, errors");
            $finish;
        end
    end

    initial
    begin : run_proc
        int    frame_no;
        int    pick;
        int    body_len;
        int    random_start;
        idle_t mode;

        // directed frames: edges of the header, extremes, each status
        queue_raw(1, IDLE_NONE);
        queue_raw(HEAD_LEN - 1, IDLE_NONE);
        queue_frame(0, FILL_RANDOM, 1'b0, 1'b0, 1'b0, IDLE_NONE);
        queue_frame(3, 8'hFF, 1'b0, 1'b0, 1'b0, IDLE_NONE);
        queue_frame(2, 8'h00, 1'b0, 1'b0, 1'b0, IDLE_NONE);
        queue_frame(4, FILL_RANDOM, 1'b1, 1'b0, 1'b0, IDLE_NONE);
        queue_frame(5, FILL_RANDOM, 1'b0, 1'b1, 1'b0, IDLE_NONE);
        queue_frame(5, FILL_RANDOM, 1'b0, 1'b0, 1'b1, IDLE_NONE);
        queue_frame(3, FILL_RANDOM, 1'b1, 1'b1, 1'b1, IDLE_NONE);
        queue_frame(6, FILL_RANDOM, 1'b0, 1'b1, 1'b1, IDLE_NONE);
        queue_frame(0, FILL_RANDOM, 1'b0, 1'b1, 1'b0, IDLE_NONE);
        queue_raw(HEAD_LEN + 20, IDLE_NONE);

        // random frames, mostly well formed, idling rotating every few frames
        random_start = queued_bytes;
        frame_no = 0;
        while (queued_bytes - random_start < RANDOM_BYTES)
        begin
            mode = idle_t'((frame_no / 3) % 4);
            pick = $urandom_range(99);
            if (pick < 8)
                queue_raw($urandom_range(HEAD_LEN - 1, 1), mode);
            else if (pick < 12)
                queue_raw($urandom_range(HEAD_LEN + 30, HEAD_LEN), mode);
            else
            begin
                body_len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
                queue_frame(body_len, FILL_RANDOM, $urandom_range(99) < 12,
                            $urandom_range(99) < 12, $urandom_range(99) < 12, mode);
            end
            frame_no++;
        end

        // reset, then run until everything is sent and checked
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (byte_stream.size() != 0 || in_valid || frame_results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (frame_results_due.size() != 0)
            report_error($sformatf("%0d results never arrived", frame_results_due.size()));
        if (error_count == 0)
            $display("link_frame_checker_top_test: done, clean");
        else
            $display("link_frame_checker_top_test: done, errors");
        $finish;
    end

endmodule
